// ----- hw/rtl/bwbm_pkg.sv -----
package bwbm_pkg;

    localparam int FW_W        = 11;
    localparam int FH_W        = 12;
    localparam int ROW_W       = 12;
    localparam int COL_OUT_W   = 10;
    localparam int ENTRY_W     = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);
    localparam int MIN_SIDE = 5;

    typedef struct packed {
        logic rd_en;
        logic advance;
        logic clear;
    } store_ctrl_t;

endpackage

// ----- hw/rtl/bwbm_cfg.sv -----
module bwbm_cfg #(
    parameter int MAX_WIDTH = 1024,
    parameter int WB        = 11
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bwbm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bwbm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [WB-1:0]                         used_width,
    output logic [bwbm_pkg::FH_W-1:0]             used_height
);
    import bwbm_pkg::*;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [WB-1:0]   fw_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_data[FW_W-1:0];
            end else if (cfg_index == REG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_data[FH_W-1:0];
            end
        end
    end

    always_comb begin
        fw_ext = WB'(frame_width_reg);
        priority if (fw_ext < WB'(MIN_SIDE)) begin
            used_width = WB'(MIN_SIDE);
        end else if (fw_ext > WB'(MAX_WIDTH)) begin
            used_width = WB'(MAX_WIDTH);
        end else begin
            used_width = fw_ext;
        end
        used_height = (frame_height_reg < FH_W'(MIN_SIDE)) ? FH_W'(MIN_SIDE) : frame_height_reg;
    end

endmodule

// ----- hw/rtl/bwbm_scan.sv -----
module bwbm_scan #(
    parameter int CW = 10,
    parameter int WB = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          pixel_set,
    input  logic                          frame_start,
    input  logic [WB-1:0]                 used_width,
    input  logic [bwbm_pkg::FH_W-1:0]     used_height,
    output logic [CW-1:0]                 rd_addr,
    output logic                          pix_reg,
    output logic [bwbm_pkg::ROW_W-1:0]    row_reg,
    output logic [CW-1:0]                 col_reg
);
    import bwbm_pkg::*;

    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0]    c_start;
    logic [ROW_W-1:0] r_start;
    logic [WB-1:0]    c_inc;
    logic [ROW_W:0]   r_inc;

    always_comb begin
        c_start = (frame_start || (WB'(col_cnt_reg) >= used_width)) ? '0 : col_cnt_reg;
        r_start = (frame_start || (row_cnt_reg >= used_height)) ? '0 : row_cnt_reg;
        c_inc   = WB'(c_start) + WB'(1);
        r_inc   = (ROW_W+1)'(r_start) + (ROW_W+1)'(1);
        if (c_inc >= used_width) begin
            col_cnt_next = '0;
            row_cnt_next = (r_inc >= (ROW_W+1)'(used_height)) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_cnt_next = c_inc[CW-1:0];
            row_cnt_next = r_start;
        end
        rd_addr = c_start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= pixel_set;
            row_reg <= r_start;
            col_reg <= c_start;
        end
    end

endmodule

// ----- hw/rtl/bwbm_line_store.sv -----
module bwbm_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bwbm_pkg::store_ctrl_t           ctrl,
    input  logic [CW-1:0]                   rd_addr,
    input  logic [bwbm_pkg::ENTRY_W-1:0]    wr_entry,
    output logic [bwbm_pkg::ENTRY_W-1:0]    rd_entry
);
    import bwbm_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_WIDTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [CW-1:0]      rd_addr_reg;

    logic               p1_v_reg, p2_v_reg, p3_v_reg;
    logic [CW-1:0]      p1_a_reg, p2_a_reg, p3_a_reg;
    logic [ENTRY_W-1:0] p1_d_reg, p2_d_reg, p3_d_reg;
    logic [ENTRY_W-1:0] p2_fin;

    assign p2_fin = ctrl.clear ? (p2_d_reg & 4'b1101) : p2_d_reg;

    always_comb begin
        priority if (p1_v_reg && (p1_a_reg == rd_addr_reg)) begin
            rd_entry = p1_d_reg;
        end else if (p2_v_reg && (p2_a_reg == rd_addr_reg)) begin
            rd_entry = p2_d_reg;
        end else if (p3_v_reg && (p3_a_reg == rd_addr_reg)) begin
            rd_entry = p3_d_reg;
        end else begin
            rd_entry = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (ctrl.advance && p2_v_reg) begin
            mem[p2_a_reg] <= p2_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end else if (ctrl.advance) begin
            p1_v_reg <= 1'b1;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            p1_a_reg <= rd_addr_reg;
            p1_d_reg <= wr_entry;
            p2_a_reg <= p1_a_reg;
            p2_d_reg <= p1_d_reg;
            p3_a_reg <= p2_a_reg;
            p3_d_reg <= p2_fin;
        end
    end

endmodule

// ----- hw/rtl/bwbm_judge.sv -----
module bwbm_judge #(
    parameter int CW = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              m_ready,
    input  logic                              pix,
    input  logic [bwbm_pkg::ROW_W-1:0]        row,
    input  logic [CW-1:0]                     col,
    input  logic [bwbm_pkg::ENTRY_W-1:0]      rd_entry,
    output logic [bwbm_pkg::ENTRY_W-1:0]      wr_entry,
    output logic                              mark,
    output logic                              m_valid,
    output logic                              m_center_valid,
    output logic [bwbm_pkg::ROW_W-1:0]        m_center_row,
    output logic [bwbm_pkg::COL_OUT_W-1:0]    m_center_column,
    output logic                              m_mark_center
);
    import bwbm_pkg::*;

    localparam int XW = (CW > COL_OUT_W) ? CW : COL_OUT_W;

    function automatic logic [24:0] win_bit(input int y, input int x);
        win_bit = 25'd1 << (x * 5 + y);
    endfunction

    localparam logic [24:0] BREAK_PATH =
        win_bit(2,2) | win_bit(3,0) | win_bit(3,1) | win_bit(3,3) | win_bit(3,4);
    localparam logic [24:0] BREAK_BACK =
        win_bit(0,0) | win_bit(0,1) | win_bit(0,2) | win_bit(0,3) | win_bit(0,4) |
        win_bit(1,0) | win_bit(1,1) | win_bit(1,2) | win_bit(1,3) | win_bit(1,4) |
        win_bit(2,0) | win_bit(2,1) | win_bit(2,3) | win_bit(2,4) |
        win_bit(4,0) | win_bit(4,1) | win_bit(4,2) | win_bit(4,3) | win_bit(4,4);
    localparam logic [24:0] BAND_PATH =
        win_bit(0,0) | win_bit(0,1) | win_bit(1,1) | win_bit(1,2) | win_bit(2,2) |
        win_bit(2,3) | win_bit(3,3) | win_bit(3,4) | win_bit(4,4);
    localparam logic [24:0] BAND_BACK =
        win_bit(0,2) | win_bit(0,3) | win_bit(0,4) | win_bit(1,0) |
        win_bit(1,3) | win_bit(1,4) | win_bit(2,0) | win_bit(2,1) |
        win_bit(2,4) | win_bit(3,0) | win_bit(3,1) | win_bit(3,2) |
        win_bit(4,0) | win_bit(4,1) | win_bit(4,2) | win_bit(4,3);
    localparam logic [24:0] CENTRE = win_bit(2,2);

    logic [24:0]        window_reg, window_new;
    logic [4:0]         col5;
    logic               judged, fit_break, fit_band;
    logic [CW-1:0]      col_m2;
    logic [XW-1:0]      col_ext;
    logic               m_valid_reg;

    always_comb begin
        col5       = {pix, rd_entry};
        window_new = {col5, window_reg[24:5]};
        judged     = (row >= ROW_W'(4)) && (col >= CW'(4));
        fit_break  = ((window_new & BREAK_PATH) == '0) && ((window_new & BREAK_BACK) == BREAK_BACK);
        fit_band   = ((window_new & BAND_PATH) == '0) && ((window_new & BAND_BACK) == BAND_BACK);
        mark       = advance && judged && (fit_break || fit_band);
        wr_entry   = col5[4:1];
        col_m2     = col - CW'(2);
        col_ext    = XW'(col_m2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                window_reg  <= mark ? (window_new & ~CENTRE) : window_new;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_center_valid  <= judged;
            m_center_row    <= judged ? (row - ROW_W'(2)) : '0;
            m_center_column <= judged ? col_ext[COL_OUT_W-1:0] : '0;
            m_mark_center   <= mark;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hw/rtl/binary_window_break_marker_top.sv -----
// Binary window break marker: takes binary pixels in raster order, one per clock while the
// result port does not stall, and presents exactly one result beat per pixel on the result
// port; each taken pixel is registered in the input stage and its result in the output
// register. The pace is set by the single read port of the line store, read once per pixel.
// Results carry center_valid for every centre whose 5x5 window lies inside the frame, with
// its row, column and a mark when the horizontal-break or diagonal-band template fits; a
// marked centre is treated as clear by all later windows. The line store is MAX_WIDTH
// entries of four bits and has no clearing pass: its contents after reset are undefined and
// reach only the first four rows of a frame, which are never judged. Write frame_width
// (index 0, clamped to 5..MAX_WIDTH) and frame_height (index 1, at least 5) only while idle.
module binary_window_break_marker_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_pixel_set,
    input  logic                                  s_frame_start,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_center_valid,
    output logic [bwbm_pkg::ROW_W-1:0]            m_center_row,
    output logic [bwbm_pkg::COL_OUT_W-1:0]        m_center_column,
    output logic                                  m_mark_center,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bwbm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bwbm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bwbm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    logic [WB-1:0]      used_width;
    logic [FH_W-1:0]    used_height;
    logic [CW-1:0]      rd_addr;
    logic               pix;
    logic [ROW_W-1:0]   row;
    logic [CW-1:0]      col;
    logic [ENTRY_W-1:0] rd_entry, wr_entry;
    logic               mark;
    logic               accept, advance;
    logic               s1_valid_reg;
    store_ctrl_t        store_ctrl;

    assign advance = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign store_ctrl.rd_en   = accept;
    assign store_ctrl.advance = advance;
    assign store_ctrl.clear   = mark;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    bwbm_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .WB        (WB)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .used_width  (used_width),
        .used_height (used_height)
    );

    bwbm_scan #(
        .CW (CW),
        .WB (WB)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .pixel_set   (s_pixel_set),
        .frame_start (s_frame_start),
        .used_width  (used_width),
        .used_height (used_height),
        .rd_addr     (rd_addr),
        .pix_reg     (pix),
        .row_reg     (row),
        .col_reg     (col)
    );

    bwbm_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (store_ctrl),
        .rd_addr  (rd_addr),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    bwbm_judge #(
        .CW (CW)
    ) u_judge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .m_ready         (m_ready),
        .pix             (pix),
        .row             (row),
        .col             (col),
        .rd_entry        (rd_entry),
        .wr_entry        (wr_entry),
        .mark            (mark),
        .m_valid         (m_valid),
        .m_center_valid  (m_center_valid),
        .m_center_row    (m_center_row),
        .m_center_column (m_center_column),
        .m_mark_center   (m_mark_center)
    );

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import bwbm_pkg::*;

    localparam int MAX_WIDTH       = 1024;
    localparam int WINDOW_BITS     = 25;
    localparam int CENTRE_CELL     = 12;
    localparam int ENTRY_CENTRE    = 1;
    localparam int FRAME_CELLS     = 9216;
    localparam int MAX_FRAME_BEATS = 8192;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 150;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int ERROR_PRINTS    = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(9);

    localparam logic [WINDOW_BITS-1:0] BREAK_PATH = 25'h0841108;
    localparam logic [WINDOW_BITS-1:0] BREAK_BACK = 25'h17BCEF7;
    localparam logic [WINDOW_BITS-1:0] BAND_PATH  = 25'h1861861;
    localparam logic [WINDOW_BITS-1:0] BAND_BACK  = 25'h079E79E;

    typedef struct packed {
        logic                 judged;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] column;
        logic                 mark;
    } centre_t;

    typedef struct packed {
        logic    reconfig;
        logic    pix;
        logic    fs;
        logic    typed;
        centre_t want;
    } probe_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic                   s_pixel_set   = 1'b0;
    logic                   s_frame_start = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_center_valid;
    logic [ROW_W-1:0]       m_center_row;
    logic [COL_OUT_W-1:0]   m_center_column;
    logic                   m_mark_center;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    logic [FW_W-1:0]        frame_w = FRAME_WIDTH_RESET;
    logic [FH_W-1:0]        frame_h = FRAME_HEIGHT_RESET;
    logic [ENTRY_W-1:0]     line_rows [0:MAX_WIDTH-1];
    logic [WINDOW_BITS-1:0] window_now = '0;
    int                     col_pos = 0;
    int                     row_pos = 0;

    centre_t expected_centres [$];
    bit      frame_img [0:FRAME_CELLS-1];

    bit idle_on   = 1'b1;
    bit stall_ask = 1'b0;
    int errors        = 0;
    int beats_sent    = 0;
    int settings_run  = 0;
    int centres_seen  = 0;
    int marks_seen    = 0;
    int cycles        = 0;

    binary_window_break_marker_top #(
        .MAX_WIDTH(MAX_WIDTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_set    (s_pixel_set),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_center_valid (m_center_valid),
        .m_center_row   (m_center_row),
        .m_center_column(m_center_column),
        .m_mark_center  (m_mark_center),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int used_width();
        int w;
        w = frame_w;
        if (w < MIN_SIDE) w = MIN_SIDE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int used_height();
        int h;
        h = frame_h;
        if (h < MIN_SIDE) h = MIN_SIDE;
        return h;
    endfunction

    function automatic bit window_fits(input logic [WINDOW_BITS-1:0] w,
                                       input logic [WINDOW_BITS-1:0] path,
                                       input logic [WINDOW_BITS-1:0] back);
        return ((w & path) == '0) && ((w & back) == back);
    endfunction

    function automatic centre_t predict_centre(input logic pix, input logic fs);
        int         w;
        int         h;
        int         r;
        int         c;
        logic [4:0] column;
        centre_t    res;
        w = used_width();
        h = used_height();
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        column = {pix, line_rows[c]};
        line_rows[c] = column[4:1];
        window_now = {column, window_now[WINDOW_BITS-1:5]};
        res = '0;
        if (r >= 4 && c >= 4) begin
            res.judged = 1'b1;
            res.row    = ROW_W'(r - 2);
            res.column = COL_OUT_W'(c - 2);
            res.mark   = window_fits(window_now, BREAK_PATH, BREAK_BACK) ||
                         window_fits(window_now, BAND_PATH, BAND_BACK);
            if (res.mark) begin
                window_now[CENTRE_CELL] = 1'b0;
                line_rows[c - 2][ENTRY_CENTRE] = 1'b0;
            end
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
        return res;
    endfunction

    task automatic send_pixel(input logic pix, input logic fs, input bit typed,
                              input centre_t typed_want);
        centre_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_pixel_set   <= pix;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_centre(pix, fs);
        expected_centres.push_back(typed ? typed_want : predicted);
        beats_sent++;
    endtask

    task automatic stream_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic settle();
        while (expected_centres.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = val[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_h = val[FH_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] wdat, input logic [CFG_DATA_W-1:0] hdat,
                             input int budget, input bit idle, input bit squeeze);
        int                     w;
        int                     h;
        int                     n;
        int                     i;
        int                     b;
        int                     nrows;
        int                     y0;
        int                     x0;
        int                     sent;
        bit                     noise;
        logic                   fs;
        logic [WINDOW_BITS-1:0] path;
        logic [WINDOW_BITS-1:0] back;
        settle();
        cfg_write(REG_FRAME_WIDTH, wdat);
        cfg_write(REG_FRAME_HEIGHT, hdat);
        settings_run++;
        idle_on = idle;
        w = used_width();
        h = used_height();
        sent = 0;
        if (squeeze) stall_ask = 1'b1;
        while (sent < budget) begin
            n = w * h;
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
            if (n > budget - sent) n = budget - sent;
            if (n > MAX_FRAME_BEATS) n = MAX_FRAME_BEATS;
            nrows = (n + w - 1) / w;
            noise = ($urandom_range(0, 4) == 0);
            for (i = 0; i < nrows * w; i++)
                frame_img[i] = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) != 0);
            if (!noise && nrows >= 5) begin
                repeat (nrows * w / 30 + 1) begin
                    y0 = $urandom_range(0, nrows - 5);
                    x0 = $urandom_range(0, w - 5);
                    if ($urandom_range(0, 1) == 1) begin
                        path = BREAK_PATH;
                        back = BREAK_BACK;
                    end else begin
                        path = BAND_PATH;
                        back = BAND_BACK;
                    end
                    for (b = 0; b < WINDOW_BITS; b++) begin
                        if (path[b]) frame_img[(y0 + b % 5) * w + x0 + b / 5] = 1'b0;
                        else if (back[b]) frame_img[(y0 + b % 5) * w + x0 + b / 5] = 1'b1;
                    end
                end
            end
            for (i = 0; i < n; i++) begin
                if (i == 0)
                    fs = (col_pos != 0 || row_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
                else
                    fs = noise && ($urandom_range(0, 49) == 0);
                send_pixel(frame_img[i], fs, 1'b0, '0);
            end
            sent += n;
        end
        stream_idle();
    endtask

    initial begin : result_sink
        int burst;
        burst = 0;
        forever begin
            @(negedge aclk);
            if (stall_ask) begin
                // hold off long enough for the block to fill and stall its input
                stall_ask = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(0, 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : centre_check
        centre_t got;
        centre_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_center_valid, m_center_row, m_center_column, m_mark_center};
            if (got.judged === 1'b1) centres_seen++;
            if (got.mark === 1'b1) marks_seen++;
            if (expected_centres.size() == 0) begin
                errors++;
                if (errors <= ERROR_PRINTS)
                    $display("%0t unexpected result beat: valid %0b row %0d column %0d mark %0b",
                             $time, got.judged, got.row, got.column, got.mark);
            end else begin
                want = expected_centres.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= ERROR_PRINTS)
                        $display("%0t mismatch: expected valid %0b row %0d column %0d mark %0b, %s",
                                 $time, want.judged, want.row, want.column, want.mark,
                                 $sformatf("got valid %0b row %0d column %0d mark %0b",
                                           got.judged, got.row, got.column, got.mark));
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t cycle limit reached, %0d results outstanding",
                     $time, expected_centres.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        probe_t  dir_tab [$];
        centre_t no_centre;
        centre_t break_hit;
        int      b;
        int      k;
        no_centre = '0;
        break_hit = {1'b1, ROW_W'(2), COL_OUT_W'(2), 1'b1};
        for (k = 0; k < MAX_WIDTH; k++) line_rows[k] = '0;

        // reset settings: no centre can be judged yet
        dir_tab.push_back({1'b0, 1'b1, 1'b1, 1'b1, no_centre});
        dir_tab.push_back({1'b0, 1'b0, 1'b0, 1'b1, no_centre});
        // 5x5 frame holding the horizontal break, judged on its last pixel
        for (b = 0; b < WINDOW_BITS; b++)
            dir_tab.push_back({b == 0, !BREAK_PATH[(b % 5) * 5 + b / 5], b == 0, 1'b1,
                               (b == WINDOW_BITS - 1) ? break_hit : no_centre});
        // frame end wraps to the origin without a frame start
        dir_tab.push_back({1'b0, 1'b1, 1'b0, 1'b1, no_centre});
        dir_tab.push_back({1'b0, 1'b0, 1'b1, 1'b0, no_centre});

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < dir_tab.size(); k++) begin
            if (dir_tab[k].reconfig) begin
                stream_idle();
                settle();
                cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(3));
                cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(0));
                cfg_write(REG_SPARE, CFG_DATA_W'(7));
                settings_run++;
            end
            send_pixel(dir_tab[k].pix, dir_tab[k].fs, dir_tab[k].typed, dir_tab[k].want);
        end
        stream_idle();

        run_phase(12'h000, 12'h003, 150, 1'b1, 1'b0);
        run_phase(12'd7, 12'd9, 200, $urandom_range(0, 3) != 0, 1'b0);
        run_phase(12'd16, 12'd6, 200, 1'b1, 1'b1);
        run_phase(12'h400, 12'd5, 60, $urandom_range(0, 3) != 0, 1'b0);
        run_phase(12'hFFF, 12'hFFF, 120, 1'b1, 1'b0);
        run_phase(12'd12, 12'd4095, 250, $urandom_range(0, 3) != 0, 1'b0);
        repeat (3)
            run_phase(CFG_DATA_W'($urandom_range(5, 24)), CFG_DATA_W'($urandom_range(5, 12)),
                      100, $urandom_range(0, 3) != 0, 1'b0);
        run_phase(12'd9, 12'd7, 150, 1'b0, 1'b0);

        settle();
        $display("Covered %0d pixel beats over %0d frame settings: %0d centres judged, %0d marked",
                 beats_sent, settings_run, centres_seen, marks_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d result errors", errors);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
